// ===== hw/rtl/xerd_pkg.sv =====
// ----------------------------------------------------------------------------
// xerd_pkg
// Shared types and constants for the XML entity reference decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xerd_pkg;

    localparam int MAX_REF_LEN_DEF = 32;

    localparam int CP_W     = 21;
    localparam int STATUS_W = 3;

    localparam logic [CP_W-1:0] CP_LIMIT  = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SAT    = 21'h110000;
    localparam logic [CP_W-1:0] SUR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SUR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] UTF2_MIN  = 21'h000080;
    localparam logic [CP_W-1:0] UTF3_MIN  = 21'h000800;
    localparam logic [CP_W-1:0] UTF4_MIN  = 21'h010000;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    localparam logic [STATUS_W-1:0] ST_DATA    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNTERM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOHEX   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LONG    = 3'd5;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;

    typedef struct packed {
        logic            ok;
        logic            over;
        logic [CP_W-1:0] value;
    } acc_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/xerd_digit_unit.sv =====
// ----------------------------------------------------------------------------
// xerd_digit_unit
// Digit classify and code point multiply-accumulate step (base 10 or 16).
// ----------------------------------------------------------------------------
`default_nettype none

module xerd_digit_unit (
    input  wire logic [xerd_pkg::CP_W-1:0] value,
    input  wire logic [7:0]                ch,
    input  wire logic                      hex,
    output xerd_pkg::acc_result_t          result
);
    import xerd_pkg::*;

    logic [3:0]  dig;
    logic        ok;
    logic [24:0] scaled;
    logic [24:0] sum;

    always_comb
    begin
        dig = 4'd0;
        ok  = 1'b0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            ok  = 1'b1;
            dig = 4'(ch - CH_0);
        end
        else if (hex && ch >= CH_LA && ch <= CH_LF)
        begin
            ok  = 1'b1;
            dig = 4'(ch - CH_LA + 8'd10);
        end
        else if (hex && ch >= CH_UA && ch <= CH_UF)
        begin
            ok  = 1'b1;
            dig = 4'(ch - CH_UA + 8'd10);
        end

        if (hex)
            scaled = {value, 4'b0000};
        else
            scaled = {1'b0, value, 3'b000} + {3'b000, value, 1'b0};
        sum = scaled + {21'd0, dig};

        result.ok    = ok;
        result.over  = sum > {4'd0, CP_LIMIT};
        result.value = sum[CP_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/xml_entity_reference_decoder_core.sv =====
// ----------------------------------------------------------------------------
// xml_entity_reference_decoder_core
// XML character and named reference decoder, bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries data_byte and end_of_stream.
//   Output channel out_valid/out_ready carries out_byte, last_of_run and
//   status; last_of_run marks the final result of one input request.
//   cfg_valid/cfg_ready writes decode_enable; cfg_ready is always high.
//   Each result is registered and appears in the cycle after its request
//   is accepted. Plain text and single-result requests run at one per cycle
//   unless the output stalls. A multi-byte UTF-8 result or a replayed
//   reference holds in_ready low while its remaining bytes are sent, and a
//   replay reads the body buffer RAM one byte per cycle when not stalled.
//   Reset clears mode and sequencer state and sets decode_enable; the body
//   buffer needs no clearing pass. When the receiver stalls, the output
//   register holds and in_ready drops until the pending result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module xml_entity_reference_decoder_core #(
    parameter int MAX_REF_LEN = xerd_pkg::MAX_REF_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          end_of_stream,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         out_byte,
    output logic                               last_of_run,
    output logic [xerd_pkg::STATUS_W-1:0]      status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          decode_enable
);
    import xerd_pkg::*;

    localparam int LW = $clog2(MAX_REF_LEN + 1);
    localparam int AW = $clog2(MAX_REF_LEN);

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_REF  = 2'd1;
    localparam logic [1:0] MODE_DROP = 2'd2;

    localparam logic [1:0] SEQ_IDLE   = 2'd0;
    localparam logic [1:0] SEQ_REPLAY = 2'd1;
    localparam logic [1:0] SEQ_TAIL   = 2'd2;
    localparam logic [1:0] SEQ_UTF    = 2'd3;

    logic [1:0]          mode_reg, mode_next;
    logic [1:0]          seq_reg, seq_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [CP_W-1:0]     cp_reg, cp_next;
    logic                inv_reg, inv_next;
    logic                en_reg;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [1:0]          ucnt_reg, ucnt_next;
    logic [7:0]          u_reg [3];
    logic [7:0]          u_next [3];
    logic [7:0]          sh_reg [4];
    logic                sh_we;
    logic [7:0]          mem [MAX_REF_LEN];
    logic                mem_we;
    logic [7:0]          rdata_reg;

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_load;

    logic                slot_free;
    logic                in_fire;
    logic                is_named;
    logic [7:0]          named_ch;
    logic                is_num;
    logic                hex_empty;
    logic                cp_ok;
    logic [7:0]          utf_b [4];
    logic [2:0]          utf_k;
    acc_result_t         acc;

    xerd_digit_unit u_digit (
        .value  (cp_reg),
        .ch     (data_byte),
        .hex    ((len_reg >= LW'(2)) && (sh_reg[1] == CH_X)),
        .result (acc)
    );

    // reference classification from the first body bytes
    always_comb
    begin
        is_named = 1'b1;
        named_ch = CH_LT;
        if (len_reg == LW'(2) && sh_reg[0] == CH_L && sh_reg[1] == CH_T)
            named_ch = CH_LT;
        else if (len_reg == LW'(2) && sh_reg[0] == CH_G && sh_reg[1] == CH_T)
            named_ch = CH_GT;
        else if (len_reg == LW'(3) && sh_reg[0] == CH_A && sh_reg[1] == CH_M
                 && sh_reg[2] == CH_P)
            named_ch = CH_AMP;
        else if (len_reg == LW'(4) && sh_reg[0] == CH_A && sh_reg[1] == CH_P
                 && sh_reg[2] == CH_O && sh_reg[3] == CH_S)
            named_ch = CH_APOS;
        else if (len_reg == LW'(4) && sh_reg[0] == CH_Q && sh_reg[1] == CH_U
                 && sh_reg[2] == CH_O && sh_reg[3] == CH_T)
            named_ch = CH_QUOT;
        else
            is_named = 1'b0;

        is_num    = (sh_reg[0] == CH_HASH) && (len_reg >= LW'(2));
        hex_empty = (sh_reg[1] == CH_X) && (len_reg == LW'(2));
        cp_ok     = !inv_reg && !(cp_reg >= SUR_LO && cp_reg <= SUR_HI)
                    && (cp_reg <= CP_LIMIT);
    end

    // UTF-8 encode of the accumulated code point
    always_comb
    begin
        utf_b[0] = cp_reg[7:0];
        utf_b[1] = 8'd0;
        utf_b[2] = 8'd0;
        utf_b[3] = 8'd0;
        utf_k    = 3'd1;
        if (cp_reg < UTF2_MIN)
        begin
            utf_k = 3'd1;
        end
        else if (cp_reg < UTF3_MIN)
        begin
            utf_k    = 3'd2;
            utf_b[0] = LEAD2 | {3'b000, cp_reg[10:6]};
            utf_b[1] = CONT | {2'b00, cp_reg[5:0]};
        end
        else if (cp_reg < UTF4_MIN)
        begin
            utf_k    = 3'd3;
            utf_b[0] = LEAD3 | {4'b0000, cp_reg[15:12]};
            utf_b[1] = CONT | {2'b00, cp_reg[11:6]};
            utf_b[2] = CONT | {2'b00, cp_reg[5:0]};
        end
        else
        begin
            utf_k    = 3'd4;
            utf_b[0] = LEAD4 | {5'b00000, cp_reg[20:18]};
            utf_b[1] = CONT | {2'b00, cp_reg[17:12]};
            utf_b[2] = CONT | {2'b00, cp_reg[11:6]};
            utf_b[3] = CONT | {2'b00, cp_reg[5:0]};
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        cp_next       = cp_reg;
        inv_next      = inv_reg;
        ptr_next      = ptr_reg;
        ucnt_next     = ucnt_reg;
        for (int i = 0; i < 3; i++)
            u_next[i] = u_reg[i];
        sh_we         = 1'b0;
        mem_we        = 1'b0;
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        status_next   = status_reg;

        slot_free = !out_valid_reg || out_ready;
        in_fire   = in_valid && (seq_reg == SEQ_IDLE) && slot_free;

        case (seq_reg)
            SEQ_IDLE:
            begin
                if (in_fire && end_of_stream)
                begin
                    mode_next = MODE_TEXT;
                    if (mode_reg == MODE_TEXT)
                    begin
                        out_load      = 1'b1;
                        out_byte_next = 8'd0;
                        last_next     = 1'b1;
                        status_next   = ST_END;
                    end
                    else if (mode_reg == MODE_REF)
                    begin
                        out_load      = 1'b1;
                        out_byte_next = 8'd0;
                        last_next     = 1'b1;
                        status_next   = ST_UNTERM;
                    end
                end
                else if (in_fire)
                begin
                    case (mode_reg)
                        MODE_TEXT:
                        begin
                            if (data_byte == CH_AMP && en_reg)
                            begin
                                mode_next = MODE_REF;
                                len_next  = '0;
                                cp_next   = '0;
                                inv_next  = 1'b0;
                            end
                            else
                            begin
                                out_load      = 1'b1;
                                out_byte_next = data_byte;
                                last_next     = 1'b1;
                                status_next   = ST_DATA;
                            end
                        end
                        MODE_REF:
                        begin
                            if (data_byte == CH_SEMI)
                            begin
                                out_load    = 1'b1;
                                status_next = ST_DATA;
                                mode_next   = MODE_TEXT;
                                if (len_reg == '0)
                                begin
                                    out_byte_next = 8'd0;
                                    last_next     = 1'b1;
                                    status_next   = ST_EMPTY;
                                    mode_next     = MODE_DROP;
                                end
                                else if (is_named)
                                begin
                                    out_byte_next = named_ch;
                                    last_next     = 1'b1;
                                end
                                else if (is_num && hex_empty)
                                begin
                                    out_byte_next = 8'd0;
                                    last_next     = 1'b1;
                                    status_next   = ST_NOHEX;
                                    mode_next     = MODE_DROP;
                                end
                                else if (is_num && cp_ok)
                                begin
                                    out_byte_next = utf_b[0];
                                    last_next     = (utf_k == 3'd1);
                                    u_next[0]     = utf_b[1];
                                    u_next[1]     = utf_b[2];
                                    u_next[2]     = utf_b[3];
                                    ucnt_next     = 2'(utf_k - 3'd1);
                                    if (utf_k != 3'd1)
                                        seq_next = SEQ_UTF;
                                end
                                else
                                begin
                                    out_byte_next = CH_AMP;
                                    last_next     = 1'b0;
                                    ptr_next      = '0;
                                    seq_next      = SEQ_REPLAY;
                                end
                            end
                            else if (len_reg >= LW'(MAX_REF_LEN))
                            begin
                                out_load      = 1'b1;
                                out_byte_next = 8'd0;
                                last_next     = 1'b1;
                                status_next   = ST_LONG;
                                mode_next     = MODE_DROP;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                sh_we    = (len_reg < LW'(4));
                                len_next = len_reg + LW'(1);
                                if (len_reg == '0)
                                begin
                                    if (data_byte != CH_HASH)
                                        inv_next = 1'b1;
                                end
                                else if (len_reg == LW'(1) && data_byte == CH_X)
                                begin
                                    inv_next = inv_reg;
                                end
                                else if (!acc.ok)
                                begin
                                    inv_next = 1'b1;
                                end
                                else if (!inv_reg)
                                begin
                                    if (acc.over)
                                    begin
                                        inv_next = 1'b1;
                                        cp_next  = CP_SAT;
                                    end
                                    else
                                    begin
                                        cp_next = acc.value;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            SEQ_REPLAY:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = rdata_reg;
                    last_next     = 1'b0;
                    status_next   = ST_DATA;
                    ptr_next      = ptr_reg + AW'(1);
                    if (LW'(ptr_reg) + LW'(1) == len_reg)
                        seq_next = SEQ_TAIL;
                end
            end
            SEQ_TAIL:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = CH_SEMI;
                    last_next     = 1'b1;
                    status_next   = ST_DATA;
                    seq_next      = SEQ_IDLE;
                end
            end
            SEQ_UTF:
            begin
                if (slot_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = u_reg[0];
                    last_next     = (ucnt_reg == 2'd1);
                    status_next   = ST_DATA;
                    u_next[0]     = u_reg[1];
                    u_next[1]     = u_reg[2];
                    ucnt_next     = ucnt_reg - 2'd1;
                    if (ucnt_reg == 2'd1)
                        seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TEXT;
            seq_reg       <= SEQ_IDLE;
            len_reg       <= '0;
            cp_reg        <= '0;
            inv_reg       <= 1'b0;
            en_reg        <= 1'b1;
            ptr_reg       <= '0;
            ucnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            seq_reg       <= seq_next;
            len_reg       <= len_next;
            cp_reg        <= cp_next;
            inv_reg       <= inv_next;
            ptr_reg       <= ptr_next;
            ucnt_reg      <= ucnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
                en_reg <= decode_enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[len_reg[AW-1:0]] <= data_byte;
        rdata_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk)
    begin
        if (sh_we)
            sh_reg[len_reg[1:0]] <= data_byte;
        for (int i = 0; i < 3; i++)
            u_reg[i] <= u_next[i];
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
    end

    assign in_ready    = (seq_reg == SEQ_IDLE) && slot_free;
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_emit_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != SEQ_IDLE |-> mode_reg == MODE_TEXT)
        else $error("emission sequence outside text mode");

    a_replay_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg == SEQ_REPLAY |-> (len_reg != '0) && (LW'(ptr_reg) < len_reg))
        else $error("replay pointer beyond buffered body");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_DATA |-> last_reg && out_byte_reg == 8'd0)
        else $error("status result not a single final result");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_REF_LEN))
        else $error("reference length beyond buffer");
`endif

endmodule

`default_nettype wire

// ===== tb/xml_entity_reference_decoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// xml_entity_reference_decoder_core_tb
// Self-checking bench for the XML reference decoder. A driver feeds text
// bytes from a request queue, a scoreboard model predicts each decoded byte
// and status, and a monitor compares every output request with it in order.
// Directed text covers named, numeric, replayed and malformed references,
// random documents cover the rest, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module xml_entity_reference_decoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import xerd_pkg::*;

    localparam int REF_DEPTH      = MAX_REF_LEN_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum logic [1:0] {SCAN_TEXT, SCAN_REF, SCAN_DROP} scan_t;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } text_req_t;

    typedef struct {
        logic [7:0]          ch;
        logic                last;
        logic [STATUS_W-1:0] st;
    } decoded_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [7:0]          data_byte     = 8'h00;
    logic                end_of_stream = 1'b0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [7:0]          out_byte;
    logic                last_of_run;
    logic [STATUS_W-1:0] status;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    logic                decode_enable = 1'b0;

    xml_entity_reference_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .decode_enable (decode_enable)
    );

    always #5 clk = ~clk;

    text_req_t   pending_bytes[$];
    decoded_t    decoded_q[$];
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned live_count   = 0;
    int unsigned in_gap_pct   = 0;
    int unsigned out_stall_pct = 0;
    bit          holding      = 1'b0;

    // decoder model state
    scan_t           scan      = SCAN_TEXT;
    logic [7:0]      body [REF_DEPTH];
    int unsigned     body_len  = 0;
    logic [CP_W-1:0] cp_val    = '0;
    logic            cp_bad    = 1'b0;
    logic            decode_on = 1'b1;
    decoded_t        run_buf [REF_DEPTH+2];
    int unsigned     run_n;

    function automatic int unsigned draw_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [4:0] digit_val(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return 5'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF)
            return 5'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UF)
            return 5'(c - CH_UA + 8'd10);
        return 5'd16;
    endfunction

    function automatic bit body_is(input string s);
        if (body_len != s.len())
            return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (body[i] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic emit(input logic [7:0] ch, input logic [STATUS_W-1:0] st);
        run_buf[run_n] = '{ch, 1'b0, st};
        run_n++;
    endtask

    task automatic accumulate_digit(input int unsigned idx, input logic [7:0] c);
        logic [4:0]      base;
        logic [4:0]      dig;
        logic [CP_W+4:0] acc;
        if (idx == 0) begin
            if (c != CH_HASH)
                cp_bad = 1'b1;
            return;
        end
        if (idx == 1 && c == CH_X)
            return;
        base = (idx >= 2 && body[1] == CH_X) ? 5'd16 : 5'd10;
        dig  = digit_val(c);
        if (dig >= base) begin
            cp_bad = 1'b1;
            return;
        end
        if (cp_bad)
            return;
        acc = cp_val * base + dig;
        if (acc > CP_LIMIT) begin
            cp_bad = 1'b1;
            cp_val = CP_SAT;
        end
        else
            cp_val = acc[CP_W-1:0];
    endtask

    task automatic close_ref();
        logic [CP_W-1:0] v;
        v = cp_val;
        if (body_len == 0) begin
            emit(8'h00, ST_EMPTY);
            scan = SCAN_DROP;
            return;
        end
        scan = SCAN_TEXT;
        if (body_is("lt"))        begin emit(CH_LT, ST_DATA);   return; end
        if (body_is("gt"))        begin emit(CH_GT, ST_DATA);   return; end
        if (body_is("amp"))       begin emit(CH_AMP, ST_DATA);  return; end
        if (body_is("apos"))      begin emit(CH_APOS, ST_DATA); return; end
        if (body_is("quot"))      begin emit(CH_QUOT, ST_DATA); return; end
        if (body[0] == CH_HASH && body_len >= 2) begin
            if (body[1] == CH_X && body_len == 2) begin
                emit(8'h00, ST_NOHEX);
                scan = SCAN_DROP;
                return;
            end
            if (!cp_bad && !(v >= SUR_LO && v <= SUR_HI) && v <= CP_LIMIT) begin
                if (v < UTF2_MIN)
                    emit(v[7:0], ST_DATA);
                else if (v < UTF3_MIN) begin
                    emit(LEAD2 | {3'b0, v[10:6]}, ST_DATA);
                    emit(CONT | {2'b0, v[5:0]}, ST_DATA);
                end
                else if (v < UTF4_MIN) begin
                    emit(LEAD3 | {4'b0, v[15:12]}, ST_DATA);
                    emit(CONT | {2'b0, v[11:6]}, ST_DATA);
                    emit(CONT | {2'b0, v[5:0]}, ST_DATA);
                end
                else begin
                    emit(LEAD4 | {5'b0, v[20:18]}, ST_DATA);
                    emit(CONT | {2'b0, v[17:12]}, ST_DATA);
                    emit(CONT | {2'b0, v[11:6]}, ST_DATA);
                    emit(CONT | {2'b0, v[5:0]}, ST_DATA);
                end
                return;
            end
        end
        // unknown or invalid: replay original text
        emit(CH_AMP, ST_DATA);
        for (int i = 0; i < body_len; i++)
            emit(body[i], ST_DATA);
        emit(CH_SEMI, ST_DATA);
    endtask

    task automatic decode_step(input logic [7:0] c, input logic eos);
        run_n = 0;
        if (eos) begin
            if (scan == SCAN_TEXT)
                emit(8'h00, ST_END);
            else if (scan == SCAN_REF)
                emit(8'h00, ST_UNTERM);
            scan = SCAN_TEXT;
        end
        else begin
            case (scan)
                SCAN_TEXT:
                    if (c == CH_AMP && decode_on) begin
                        scan     = SCAN_REF;
                        body_len = 0;
                        cp_val   = '0;
                        cp_bad   = 1'b0;
                    end
                    else
                        emit(c, ST_DATA);
                SCAN_REF:
                    if (c == CH_SEMI)
                        close_ref();
                    else if (body_len >= REF_DEPTH) begin
                        emit(8'h00, ST_LONG);
                        scan = SCAN_DROP;
                    end
                    else begin
                        accumulate_digit(body_len, c);
                        body[body_len] = c;
                        body_len++;
                    end
                default: ;
            endcase
        end
        for (int i = 0; i < run_n; i++) begin
            run_buf[i].last = (i == run_n - 1);
            decoded_q.push_back(run_buf[i]);
        end
    endtask

    // driver
    int unsigned gap_left = 0;
    always @(posedge clk) begin
        text_req_t req;
        if (!rst_n) begin
            in_valid <= 1'b0;
            holding = 1'b0;
        end
        else begin
            if (in_valid && in_ready) begin
                decode_step(data_byte, end_of_stream);
                holding = 1'b0;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0) begin
                    req = pending_bytes.pop_front();
                    in_valid      <= 1'b1;
                    data_byte     <= req.data;
                    end_of_stream <= req.eos;
                    holding  = 1'b1;
                    gap_left = draw_gap(in_gap_pct);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and scoreboard
    int unsigned stall_left = 0;
    always @(posedge clk) begin
        decoded_t exp_b;
        if (!rst_n) begin
            out_ready <= 1'b0;
            quiet_cycles = 0;
        end
        else begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid && out_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result byte %02h last %0b status %0d",
                             $time, out_byte, last_of_run, status);
                    error_count++;
                end
                else begin
                    exp_b = decoded_q.pop_front();
                    if (out_byte !== exp_b.ch) begin
                        $display("%0t: out_byte expected %02h, got %02h",
                                 $time, exp_b.ch, out_byte);
                        error_count++;
                    end
                    if (last_of_run !== exp_b.last) begin
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, exp_b.last, last_of_run);
                        error_count++;
                    end
                    if (status !== exp_b.st) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, exp_b.st, status);
                        error_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                stall_left = draw_gap(out_stall_pct);
            end
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus helpers
    task automatic add_byte(input logic [7:0] b, input logic eos, input bit live);
        pending_bytes.push_back('{b, eos});
        if (live)
            live_count++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], 1'b0, 1'b1);
    endtask

    task automatic add_eos(input bit live);
        add_byte(8'($urandom_range(0, 255)), 1'b1, live);
    endtask

    function automatic logic [7:0] body_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SEMI);
        return b;
    endfunction

    task automatic add_body(input int unsigned n);
        for (int i = 0; i < n; i++)
            add_byte(body_char(), 1'b0, 1'b1);
    endtask

    task automatic add_numeric(input int unsigned v, input bit hex, input bit bad);
        string digits;
        string bad_pool [5] = '{"g", "Z", ":", "/", "x"};
        string junk;
        digits = hex ? $sformatf("%0h", v) : $sformatf("%0d", v);
        if (hex && $urandom_range(0, 1))
            digits = digits.toupper();
        repeat ($urandom_range(0, 2))
            digits = {"0", digits};
        if (bad) begin
            junk = bad_pool[$urandom_range(0, 4)];
            digits = $urandom_range(0, 1) ? {junk, digits} : {digits, junk};
        end
        if (hex)
            digits = {"x", digits};
        add_text({"&#", digits, ";"});
    endtask

    function automatic int unsigned valid_code_point();
        int unsigned v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 'h7F);
            1: v = $urandom_range('h80, 'h7FF);
            2: do v = $urandom_range('h800, 'hFFFF); while (v >= 'hD800 && v <= 'hDFFF);
            default: v = $urandom_range('h10000, 'h10FFFF);
        endcase
        return v;
    endfunction

    task automatic add_error_case();
        case ($urandom_range(0, 3))
            0: add_text("&;");
            1: add_text("&#x;");
            2: begin
                add_text("&");
                add_body(REF_DEPTH + 1);
            end
            default: begin
                add_text("&");
                add_body($urandom_range(0, 6));
            end
        endcase
        repeat ($urandom_range(0, 4))
            add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_eos(1'b0);
    endtask

    task automatic random_document(input int unsigned target);
        string names [5] = '{"lt", "gt", "amp", "apos", "quot"};
        int unsigned r;
        live_count = 0;
        while (live_count < target) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                repeat ($urandom_range(1, 6))
                    add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            else if (r < 45)
                add_text({"&", names[$urandom_range(0, 4)], ";"});
            else if (r < 68)
                add_numeric(valid_code_point(), 1'($urandom_range(0, 1)), 1'b0);
            else if (r < 72)
                add_numeric($urandom_range('hD800, 'hDFFF), 1'($urandom_range(0, 1)), 1'b0);
            else if (r < 75)
                add_numeric($urandom_range('h110000, 'h3FFFFFF), 1'($urandom_range(0, 1)),
                            1'b0);
            else if (r < 79)
                add_numeric(valid_code_point(), 1'($urandom_range(0, 1)), 1'b1);
            else if (r < 87) begin
                add_text("&");
                add_body($urandom_range(1, 12));
                add_text(";");
            end
            else if (r < 89) begin
                add_text("&");
                add_body($urandom_range(20, REF_DEPTH));
                add_text(";");
            end
            else if (r < 94)
                add_eos(1'b1);
            else
                add_error_case();
        end
    endtask

    task automatic drain();
        while (pending_bytes.size() != 0 || holding || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_decode(input logic en);
        drain();
        cfg_valid     <= 1'b1;
        decode_enable <= en;
        do
            @(posedge clk);
        while (!cfg_ready);
        decode_on = en;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, decode enabled out of reset
        add_text("A");
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'hFF, 1'b0, 1'b1);
        add_text("&lt;&gt;&amp;&apos;&quot;");
        add_text("&#0;&#65;&#x7f;&#xE9;&#x20AC;&#x1F600;&#1114111;&#00065;");
        add_text("&#xD800;&#xdfff;&#x110000;&#12a;&#;&#X41;&foo;&a&b;");
        add_text("&");
        add_body(REF_DEPTH);
        add_text(";");
        add_eos(1'b1);
        add_text("&ab");
        add_eos(1'b1);
        add_text("&;q");
        add_eos(1'b1);
        add_text("&#x;");
        add_eos(1'b1);
        add_text("&");
        add_body(REF_DEPTH + 1);
        add_byte(8'hFF, 1'b1, 1'b1);
        // open reference survives a disable
        add_text("&amp");
        set_decode(1'b0);
        add_text(";&lt;&#65;x");
        add_eos(1'b1);

        in_gap_pct    = 25;
        out_stall_pct = 25;
        set_decode(1'b1);
        random_document(10);

        set_decode(1'b0);
        random_document(6);

        in_gap_pct    = 0;
        out_stall_pct = 0;
        set_decode(1'b1);
        random_document(6);

        in_gap_pct    = 30;
        out_stall_pct = 40;
        set_decode(1'b1);
        random_document(10);

        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
